[rtl/sdspi_pkg.sv]
package sdspi_pkg;

  localparam int unsigned BLOCK_BYTES = 512;
  localparam int unsigned IDLE_BYTES  = 10;

  localparam int unsigned CountW   = 10;
  localparam int unsigned RetryW   = 10;
  localparam int unsigned AddrW    = 24;
  localparam int unsigned SectorW  = 15;
  localparam int unsigned RetryLimW = 9;
  localparam int unsigned TokenLimW = 10;
  localparam int unsigned CfgW     = 10;

  localparam logic [7:0] TOKEN_START = 8'hFE;
  localparam logic [7:0] R1_IDLE     = 8'h01;
  localparam logic [7:0] R1_READY    = 8'h00;
  localparam logic [7:0] IDLE_BYTE   = 8'hFF;

  typedef enum logic [1:0] {
    OP_INIT = 2'd0,
    OP_READ = 2'd1,
    OP_BYTE = 2'd2
  } opcode_e;

  typedef enum logic [0:0] {
    CFG_RETRY_LIMIT = 1'b0,
    CFG_TOKEN_LIMIT = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_BUSY      = 3'd0,
    ST_OK        = 3'd1,
    ST_INIT_TO   = 3'd2,
    ST_READ_TO   = 3'd3,
    ST_NOT_READY = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    PH_OK        = 4'd0,
    PH_INIT_TO   = 4'd1,
    PH_READ_TO   = 4'd2,
    PH_NOT_READY = 4'd3,
    PH_WAKE      = 4'd4,
    PH_CMD0      = 4'd5,
    PH_CMD8      = 4'd6,
    PH_CMD55     = 4'd7,
    PH_ACMD41    = 4'd8,
    PH_CMD17     = 4'd9,
    PH_TOKEN     = 4'd10,
    PH_DATA      = 4'd11,
    PH_CRC       = 4'd12
  } phase_e;

  typedef struct packed {
    phase_e              phase;
    logic [CountW-1:0]   byte_count;
    logic [RetryW-1:0]   retry_count;
    logic [AddrW-1:0]    byte_addr;
  } seq_state_t;

  typedef struct packed {
    logic [7:0] mosi_byte;
    logic       select_low;
    logic       data_valid;
    logic [7:0] data_byte;
    logic       data_last;
    status_e    status;
  } result_t;

  function automatic logic [3:0] frame_len(phase_e ph);
    case (ph)
      PH_CMD0:   frame_len = 4'd9;
      PH_CMD8:   frame_len = 4'd13;
      PH_CMD55:  frame_len = 4'd10;
      PH_ACMD41: frame_len = 4'd9;
      default:   frame_len = 4'd8;
    endcase
  endfunction

  function automatic logic [7:0] frame_byte(phase_e ph, logic [3:0] k,
                                            logic [AddrW-1:0] addr);
    logic [7:0] b;
    b = IDLE_BYTE;
    case (ph)
      PH_CMD0: begin
        case (k)
          4'd1:    b = 8'h40;
          4'd2, 4'd3, 4'd4, 4'd5: b = 8'h00;
          4'd6:    b = 8'h95;
          default: b = IDLE_BYTE;
        endcase
      end
      PH_CMD8: begin
        case (k)
          4'd1:    b = 8'h48;
          4'd2, 4'd3: b = 8'h00;
          4'd4:    b = 8'h01;
          4'd5:    b = 8'hAA;
          4'd6:    b = 8'h87;
          default: b = IDLE_BYTE;
        endcase
      end
      PH_CMD55: begin
        case (k)
          4'd1:    b = 8'h77;
          4'd2, 4'd3, 4'd4, 4'd5: b = 8'h00;
          default: b = IDLE_BYTE;
        endcase
      end
      PH_ACMD41: begin
        case (k)
          4'd1:    b = 8'h69;
          4'd2:    b = 8'h40;
          4'd3, 4'd4, 4'd5: b = 8'h00;
          default: b = IDLE_BYTE;
        endcase
      end
      default: begin
        case (k)
          4'd1:    b = 8'h51;
          4'd2:    b = 8'h00;
          4'd3:    b = addr[23:16];
          4'd4:    b = addr[15:8];
          4'd5:    b = addr[7:0];
          4'd6:    b = 8'h00;
          default: b = IDLE_BYTE;
        endcase
      end
    endcase
    return b;
  endfunction

  function automatic status_e status_of(phase_e ph);
    case (ph)
      PH_OK:        status_of = ST_OK;
      PH_INIT_TO:   status_of = ST_INIT_TO;
      PH_READ_TO:   status_of = ST_READ_TO;
      PH_NOT_READY: status_of = ST_NOT_READY;
      default:      status_of = ST_BUSY;
    endcase
  endfunction

endpackage

[rtl/sdspi_step.sv]
module sdspi_step (
  input  sdspi_pkg::seq_state_t              cur_i,
  input  logic [sdspi_pkg::RetryLimW-1:0]    retry_limit_i,
  input  logic [sdspi_pkg::TokenLimW-1:0]    token_limit_i,
  input  logic [1:0]                         opcode_i,
  input  logic [sdspi_pkg::SectorW-1:0]      sector_i,
  input  logic [7:0]                         miso_byte_i,
  output sdspi_pkg::seq_state_t              nxt_o,
  output sdspi_pkg::result_t                 res_o
);
  import sdspi_pkg::*;

  logic [CountW-1:0] bc_inc;
  logic [RetryW-1:0] retry_inc;

  assign bc_inc    = cur_i.byte_count + CountW'(1);
  assign retry_inc = cur_i.retry_count + RetryW'(1);

  always_comb begin
    nxt_o                = cur_i;
    res_o.mosi_byte      = IDLE_BYTE;
    res_o.select_low     = 1'b1;
    res_o.data_valid     = 1'b0;
    res_o.data_byte      = 8'h00;
    res_o.data_last      = 1'b0;
    case (opcode_i)
      OP_INIT: begin
        nxt_o.phase       = PH_WAKE;
        nxt_o.byte_count  = '0;
        nxt_o.retry_count = '0;
        res_o.select_low  = 1'b0;
      end
      OP_READ: begin
        nxt_o.byte_addr  = {sector_i, 9'd0};
        nxt_o.phase      = PH_CMD17;
        nxt_o.byte_count = '0;
      end
      default: begin
        case (cur_i.phase)
          PH_WAKE: begin
            nxt_o.byte_count = bc_inc;
            if (bc_inc < CountW'(IDLE_BYTES)) begin
              res_o.select_low = 1'b0;
            end else begin
              nxt_o.phase      = PH_CMD0;
              nxt_o.byte_count = '0;
            end
          end
          PH_CMD0, PH_CMD8, PH_CMD55, PH_ACMD41, PH_CMD17: begin
            if (bc_inc < {6'd0, frame_len(cur_i.phase)}) begin
              nxt_o.byte_count = bc_inc;
              res_o.mosi_byte  = frame_byte(cur_i.phase, bc_inc[3:0], cur_i.byte_addr);
            end else begin
              case (cur_i.phase)
                PH_CMD0: begin
                  if (miso_byte_i != R1_IDLE) begin
                    nxt_o.phase      = PH_NOT_READY;
                    res_o.select_low = 1'b0;
                  end else begin
                    nxt_o.phase      = PH_CMD8;
                    nxt_o.byte_count = '0;
                  end
                end
                PH_CMD8: begin
                  nxt_o.phase      = PH_CMD55;
                  nxt_o.byte_count = '0;
                end
                PH_CMD55: begin
                  nxt_o.phase      = PH_ACMD41;
                  nxt_o.byte_count = '0;
                end
                PH_ACMD41: begin
                  nxt_o.retry_count = retry_inc;
                  if (miso_byte_i == R1_READY) begin
                    nxt_o.phase      = PH_OK;
                    res_o.select_low = 1'b0;
                  end else if (retry_inc >= {1'b0, retry_limit_i}) begin
                    nxt_o.phase      = PH_INIT_TO;
                    res_o.select_low = 1'b0;
                  end else begin
                    nxt_o.phase      = PH_CMD55;
                    nxt_o.byte_count = '0;
                  end
                end
                default: begin
                  nxt_o.phase      = PH_TOKEN;
                  nxt_o.byte_count = CountW'(1);
                end
              endcase
            end
          end
          PH_TOKEN: begin
            if (miso_byte_i == TOKEN_START) begin
              nxt_o.phase      = PH_DATA;
              nxt_o.byte_count = '0;
            end else if (cur_i.byte_count >= token_limit_i) begin
              nxt_o.phase      = PH_READ_TO;
              res_o.select_low = 1'b0;
            end else begin
              nxt_o.byte_count = bc_inc;
            end
          end
          PH_DATA: begin
            res_o.data_valid = 1'b1;
            res_o.data_byte  = miso_byte_i;
            nxt_o.byte_count = bc_inc;
            if (bc_inc >= CountW'(BLOCK_BYTES)) begin
              res_o.data_last  = 1'b1;
              nxt_o.phase      = PH_CRC;
              nxt_o.byte_count = '0;
            end
          end
          PH_CRC: begin
            nxt_o.byte_count = bc_inc;
            if (bc_inc >= CountW'(2)) begin
              nxt_o.phase      = PH_OK;
              res_o.select_low = 1'b0;
            end
          end
          default: begin
            res_o.select_low = 1'b0;
          end
        endcase
      end
    endcase
    res_o.status = status_of(nxt_o.phase);
  end

endmodule

[rtl/sd_spi_host_sequencer_top.sv]
// SD card SPI-mode host sequencer. Each input item is one byte exchange with
// the card (or a start-init / start-read command) and yields exactly one
// result item: the next byte to send, the chip-select level, any sector data
// byte and a status. One item is taken every clock cycle while s_axis_tready is
// high; each result is registered in an output register backed by a one-item
// skid register, so the input only stalls when both are full.
// Write the configuration only while no item is in flight.
module sd_spi_host_sequencer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [sdspi_pkg::CfgW-1:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // sector[14:0], miso_byte[22:15], zero
  input  logic [1:0]  s_axis_tuser,   // opcode[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // mosi_byte[7:0], select_low[8],
                                      // data_byte[16:9], status[19:17], zero
  output logic        m_axis_tlast,   // data_last
  output logic        m_axis_tuser    // data_valid
);
  import sdspi_pkg::*;

  logic [RetryLimW-1:0] retry_limit_q;
  logic [TokenLimW-1:0] token_limit_q;
  seq_state_t           state_q, state_d;
  result_t              res_d, out_q, skid_q;
  logic                 out_valid_q, skid_valid_q;
  logic                 accept, out_free;

  assign s_axis_tready = ~skid_valid_q;
  assign accept        = s_axis_tvalid & s_axis_tready;
  assign out_free      = ~out_valid_q | m_axis_tready;

  sdspi_step u_step (
    .cur_i         (state_q),
    .retry_limit_i (retry_limit_q),
    .token_limit_i (token_limit_q),
    .opcode_i      (s_axis_tuser),
    .sector_i      (s_axis_tdata[14:0]),
    .miso_byte_i   (s_axis_tdata[22:15]),
    .nxt_o         (state_d),
    .res_o         (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      retry_limit_q <= RetryLimW'(100);
      token_limit_q <= TokenLimW'(300);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_RETRY_LIMIT: retry_limit_q <= cfg_data_i[RetryLimW-1:0];
        CFG_TOKEN_LIMIT: token_limit_q <= cfg_data_i[TokenLimW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase       <= PH_OK;
      state_q.byte_count  <= '0;
      state_q.retry_count <= '0;
      state_q.byte_addr   <= '0;
    end else if (accept) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q  <= skid_valid_q | accept;
      skid_valid_q <= 1'b0;
    end else if (accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_valid_q ? skid_q : res_d;
    end
    if (!out_free && accept) begin
      skid_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0, out_q.status, out_q.data_byte, out_q.select_low,
                          out_q.mosi_byte};
  assign m_axis_tlast  = out_q.data_last;
  assign m_axis_tuser  = out_q.data_valid;

endmodule

[rtl/sdspi_checker.sv]
module sdspi_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic        m_axis_tuser
);
  import sdspi_pkg::*;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser)
    else $error("last flag without data byte");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[19:17] == ST_BUSY)
    else $error("data byte with non-busy status");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[19:17] != ST_BUSY)
      |-> !m_axis_tdata[8] && (m_axis_tdata[7:0] == IDLE_BYTE))
    else $error("select held or byte sent after sequence end");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready
      |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result item changed");

endmodule

bind sd_spi_host_sequencer_top sdspi_checker u_sdspi_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);
